// ===== design/cba_pkg.sv =====
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and widths for the complex beam accumulator.
// ----------------------------------------------------------------------------
package cba_pkg;

   localparam int WEIGHT_W = 8;
   localparam int SAMPLE_W = 8;
   localparam int SHIFT_W  = 5;
   localparam int NIBBLE_W = 4;
   localparam int PROD_W   = WEIGHT_W + NIBBLE_W;
   localparam int TERM_W   = PROD_W + 1;
   localparam int ACC_W    = 24;

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight_real;
      logic [WEIGHT_W-1:0] weight_imag;
      logic [SAMPLE_W-1:0] dish_sample;
      logic [SHIFT_W-1:0]  shift_amount;
      logic                last_dish;
   } item_type;

endpackage

// ===== design/cba_input_stage.sv =====
// ----------------------------------------------------------------------------
// cba_input_stage
// Input register: captures one request beat and holds it for the MAC stage.
// ----------------------------------------------------------------------------
module cba_input_stage
   import cba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [WEIGHT_W-1:0] req_weight_real,
   input  logic [WEIGHT_W-1:0] req_weight_imag,
   input  logic [SAMPLE_W-1:0] req_dish_sample,
   input  logic [SHIFT_W-1:0]  req_shift_amount,
   input  logic                req_last_dish,
   output logic                item_valid,
   output item_type            item,
   input  logic                item_ready
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     load;

   assign req_ready = !valid_ff || item_ready;
   assign load      = req_valid && req_ready;

   always_comb begin
      item_in = item_ff;
      if (load) begin
         item_in.weight_real  = req_weight_real;
         item_in.weight_imag  = req_weight_imag;
         item_in.dish_sample  = req_dish_sample;
         item_in.shift_amount = req_shift_amount;
         item_in.last_dish    = req_last_dish;
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== design/cba_mac.sv =====
// ----------------------------------------------------------------------------
// cba_mac
// Complex multiply-accumulate, final shift and pack, and the result register.
// ----------------------------------------------------------------------------
module cba_mac
   import cba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  item_type            item,
   output logic                item_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SAMPLE_W-1:0] rsp_beam_sample
);

   logic signed [WEIGHT_W-1:0] wr, wi;
   logic signed [NIBBLE_W-1:0] er, ei;
   logic signed [PROD_W-1:0]   p_rr, p_ii, p_ri, p_ir;
   logic [TERM_W-1:0]          term_re, term_im;
   logic [ACC_W-1:0]           acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic [ACC_W-1:0]           sum_re, sum_im;
   logic signed [ACC_W-1:0]    shr_re, shr_im;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]        beam_ff, beam_in;
   logic                       advance;

   assign item_ready = !item.last_dish || !rsp_valid_ff || rsp_ready;
   assign advance    = item_valid && item_ready;

   always_comb begin
      wr   = item.weight_real;
      wi   = item.weight_imag;
      er   = item.dish_sample[NIBBLE_W-1:0];
      ei   = item.dish_sample[SAMPLE_W-1:NIBBLE_W];
      p_rr = wr * er;
      p_ii = wi * ei;
      p_ri = wr * ei;
      p_ir = wi * er;
      term_re = {p_rr[PROD_W-1], p_rr} - {p_ii[PROD_W-1], p_ii};
      term_im = {p_ri[PROD_W-1], p_ri} + {p_ir[PROD_W-1], p_ir};
      sum_re  = acc_re_ff + {{(ACC_W-TERM_W){term_re[TERM_W-1]}}, term_re};
      sum_im  = acc_im_ff + {{(ACC_W-TERM_W){term_im[TERM_W-1]}}, term_im};
      shr_re  = $signed(sum_re) >>> item.shift_amount;
      shr_im  = $signed(sum_im) >>> item.shift_amount;

      acc_re_in    = acc_re_ff;
      acc_im_in    = acc_im_ff;
      beam_in      = beam_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance) begin
         if (item.last_dish) begin
            acc_re_in    = '0;
            acc_im_in    = '0;
            beam_in      = {shr_im[NIBBLE_W-1:0], shr_re[NIBBLE_W-1:0]};
            rsp_valid_in = 1'b1;
         end else begin
            acc_re_in = sum_re;
            acc_im_in = sum_im;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_re_ff    <= '0;
         acc_im_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_re_ff    <= acc_re_in;
         acc_im_ff    <= acc_im_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beam_ff <= beam_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_beam_sample = beam_ff;

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && item.last_dish |=> acc_re_ff == '0 && acc_im_ff == '0)
      else $error("sums not cleared after last beat");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      item_valid && item.last_dish && rsp_valid_ff && !rsp_ready |-> !advance)
      else $error("pending result overwritten");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && item.last_dish))
      else $error("result without last beat");

   a_hold_sums: assert property (@(posedge clock) disable iff (reset)
      !item_valid |=> $stable(acc_re_ff) && $stable(acc_im_ff))
      else $error("sums moved without a beat");

endmodule

// ===== design/complex_beam_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// complex_beam_accumulator_top
// Complex beamformer MAC: int8 weights times packed int4 samples, 24-bit
// sums, shift and pack to one byte on the last dish of each beam sample.
//
//   channel | handshake            | payload
//   req     | req_valid/req_ready  | weight_real, weight_imag, dish_sample,
//           |                      | shift_amount, last_dish
//   rsp     | rsp_valid/rsp_ready  | beam_sample
//
// One beat per cycle unless a stalled result holds a last-dish beat; a last
// beat goes through the input register, then MAC into the result register.
// Reset clears both sums and all valid flags; no clearing pass.
// A stalled result blocks only the next last-dish beat; other beats keep
// accumulating underneath it.
// ----------------------------------------------------------------------------
module complex_beam_accumulator_top
   import cba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [WEIGHT_W-1:0] req_weight_real,
   input  logic [WEIGHT_W-1:0] req_weight_imag,
   input  logic [SAMPLE_W-1:0] req_dish_sample,
   input  logic [SHIFT_W-1:0]  req_shift_amount,
   input  logic                req_last_dish,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SAMPLE_W-1:0] rsp_beam_sample
);

   logic     item_valid;
   logic     item_ready;
   item_type item;

   cba_input_stage u_input (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_weight_real  (req_weight_real),
      .req_weight_imag  (req_weight_imag),
      .req_dish_sample  (req_dish_sample),
      .req_shift_amount (req_shift_amount),
      .req_last_dish    (req_last_dish),
      .item_valid       (item_valid),
      .item             (item),
      .item_ready       (item_ready)
   );

   cba_mac u_mac (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (item_valid),
      .item            (item),
      .item_ready      (item_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_beam_sample (rsp_beam_sample)
   );

endmodule

// ===== verif/tb_complex_beam_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// tb_complex_beam_accumulator_top
// Self-checking bench for the complex beam accumulator. Streams dish beats
// (directed corner cases, then random beams of varying length and one full
// 512-dish beam at peak magnitude) through the request channel in random
// bursts. A scoreboard keeps its own 24-bit complex sums, predicts the packed
// beam byte on each last-dish beat and compares it with every accepted
// response beat. The response side stalls on its own pattern, including long
// hold-offs that back the block up into its request channel.
// ----------------------------------------------------------------------------
class beam_scoreboard;

   logic [cba_pkg::ACC_W-1:0] acc_real;
   logic [cba_pkg::ACC_W-1:0] acc_imag;
   logic [7:0]                expected_beams[$];
   int                        failures;

   function new();
      acc_real = '0;
      acc_imag = '0;
      failures = 0;
   endfunction

   function int pending();
      return expected_beams.size();
   endfunction

   function void note_beat(input logic [7:0] wr, input logic [7:0] wi,
                           input logic [7:0] smp, input logic [4:0] sh,
                           input logic last);
      int                        w_re;
      int                        w_im;
      int                        s_re;
      int                        s_im;
      int                        prod_re;
      int                        prod_im;
      logic signed [cba_pkg::ACC_W-1:0] sum_re;
      logic signed [cba_pkg::ACC_W-1:0] sum_im;
      logic signed [cba_pkg::ACC_W-1:0] shr_re;
      logic signed [cba_pkg::ACC_W-1:0] shr_im;
      w_re = $signed(wr);
      w_im = $signed(wi);
      s_re = $signed(smp[3:0]);
      s_im = $signed(smp[7:4]);
      prod_re = w_re * s_re - w_im * s_im;
      prod_im = w_re * s_im + w_im * s_re;
      acc_real = acc_real + prod_re[cba_pkg::ACC_W-1:0];
      acc_imag = acc_imag + prod_im[cba_pkg::ACC_W-1:0];
      if (last) begin
         sum_re = acc_real;
         sum_im = acc_imag;
         shr_re = sum_re >>> sh;
         shr_im = sum_im >>> sh;
         expected_beams.push_back({shr_im[3:0], shr_re[3:0]});
         acc_real = '0;
         acc_imag = '0;
      end
   endfunction

   function void check_beat(input logic [7:0] got);
      logic [7:0] want;
      if (expected_beams.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected beam_sample beat: actual %02h", got);
      end else begin
         want = expected_beams.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= 10)
               $display("beam_sample mismatch: expected %02h actual %02h", want, got);
         end
      end
   endfunction

endclass

module tb_complex_beam_accumulator_top;
   import cba_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LIMIT_CYCLES = 300000;
   localparam int          RANDOM_BEATS = 950;
   localparam int          DRAIN_CYCLES = 8;

   typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [WEIGHT_W-1:0] req_weight_real = '0;
   logic [WEIGHT_W-1:0] req_weight_imag = '0;
   logic [SAMPLE_W-1:0] req_dish_sample = '0;
   logic [SHIFT_W-1:0]  req_shift_amount = '0;
   logic                req_last_dish = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [SAMPLE_W-1:0] rsp_beam_sample;

   beam_scoreboard beam_sb = new();
   int unsigned    cycle_count = 0;
   int             beats_sent = 0;
   int             burst_left = 1;

   complex_beam_accumulator_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_weight_real  (req_weight_real),
      .req_weight_imag  (req_weight_imag),
      .req_dish_sample  (req_dish_sample),
      .req_shift_amount (req_shift_amount),
      .req_last_dish    (req_last_dish),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_beam_sample  (rsp_beam_sample)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("complex_beam_accumulator_top verification failed");
      $finish;
   end

   function automatic logic [7:0] pick_weight();
      case ($urandom_range(0, 7))
         0:       return 8'h80;
         1:       return 8'h7f;
         2:       return 8'h00;
         3:       return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 8'h88;
         1:       return 8'h77;
         2:       return 8'h78;
         3:       return 8'h87;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_beat(input logic [7:0] wr, input logic [7:0] wi,
                            input logic [7:0] smp, input logic [4:0] sh,
                            input logic last);
      int gap;
      req_valid        <= 1'b1;
      req_weight_real  <= wr;
      req_weight_imag  <= wi;
      req_dish_sample  <= smp;
      req_shift_amount <= sh;
      req_last_dish    <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beam_sb.note_beat(wr, wi, smp, sh, last);
      beats_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(1, 8);
         burst_left = $urandom_range(1, 40);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // response side: random stall phases plus two long hold-offs
   initial begin
      rx_mode_type mode;
      int          phase_left;
      int          hold_left;
      int unsigned rx_cycles;
      mode = RX_OPEN;
      phase_left = 0;
      hold_left = 0;
      rx_cycles = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            beam_sb.check_beat(rsp_beam_sample);
         rx_cycles++;
         if (rx_cycles == 400 || rx_cycles == 1200)
            hold_left = 300;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 3));
               phase_left = $urandom_range(20, 200);
            end
            phase_left--;
            case (mode)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   initial begin
      int         beam_idx;
      int         dishes;
      logic       last;
      logic [4:0] sh;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // single-dish beams at the extremes, large shifts with both signs
      send_beat(8'h80, 8'h80, 8'h88, 5'd0,  1'b1);
      send_beat(8'h7f, 8'h7f, 8'h77, 5'd0,  1'b1);
      send_beat(8'h80, 8'h7f, 8'h88, 5'd31, 1'b1);
      send_beat(8'h7f, 8'h80, 8'h88, 5'd31, 1'b1);
      send_beat(8'h7f, 8'h80, 8'h88, 5'd24, 1'b1);
      send_beat(8'h7f, 8'h80, 8'h88, 5'd23, 1'b1);
      send_beat(8'h80, 8'h7f, 8'h88, 5'd23, 1'b1);
      send_beat(8'h00, 8'h00, 8'h00, 5'd0,  1'b1);
      send_beat(8'hff, 8'h01, 8'hf1, 5'd1,  1'b1);
      // multi-dish beams, shift on non-last beats ignored
      send_beat(8'h55, 8'haa, 8'h5a, 5'd31, 1'b0);
      send_beat(8'haa, 8'h55, 8'ha5, 5'd21, 1'b0);
      send_beat(8'h80, 8'h80, 8'h88, 5'd10, 1'b0);
      send_beat(8'h7f, 8'h80, 8'h78, 5'd3,  1'b1);
      send_beat(8'h55, 8'h55, 8'hff, 5'd21, 1'b0);
      send_beat(8'haa, 8'haa, 8'h00, 5'd10, 1'b1);
      send_beat(8'h01, 8'hff, 8'h87, 5'd2,  1'b1);
      send_beat(8'h7f, 8'h7f, 8'h88, 5'd0,  1'b0);
      send_beat(8'h80, 8'h80, 8'h77, 5'd0,  1'b0);
      send_beat(8'hc3, 8'h3c, 8'h4b, 5'd4,  1'b1);

      beam_idx = 0;
      while (beats_sent < RANDOM_BEATS) begin
         if (beam_idx == 30) begin
            // full-length beam at peak magnitude, still inside 24 bits
            for (int d = 0; d < 512; d++) begin
               last = (d == 511);
               send_beat(8'h80, 8'h7f, 8'h88, last ? 5'd16 : 5'($urandom), last);
            end
         end else begin
            dishes = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64)
                                                 : $urandom_range(1, 12);
            for (int d = 0; d < dishes; d++) begin
               last = (d == dishes - 1);
               if (!last)
                  sh = 5'($urandom);
               else if ($urandom_range(0, 4) == 0)
                  sh = 5'($urandom_range(0, 31));
               else
                  sh = 5'($urandom_range(0, 12));
               send_beat(pick_weight(), pick_weight(), pick_sample(), sh, last);
            end
         end
         beam_idx++;
      end

      req_valid <= 1'b0;
      while (beam_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (beam_sb.failures == 0 && beam_sb.pending() == 0)
         $display("complex_beam_accumulator_top verification clean");
      else
         $display("complex_beam_accumulator_top verification failed");
      $finish;
   end

endmodule
